@@ hdl/cst_pkg.sv @@
// Package: shared types and constants of the C subset tokenizer.
package cst_pkg;

    localparam int PositionWidthDef = 32;
    localparam int KeywordBytesDef  = 8;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_DEC, M_ZERO, M_HEX0, M_HEX, M_OCT, M_SLASH,
        M_LINE, M_BLOCK, M_BSTAR, M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_PIPE
    } t_mode;

    localparam logic [5:0] K_CONST    = 6'd0;
    localparam logic [5:0] K_INT      = 6'd1;
    localparam logic [5:0] K_VOID     = 6'd2;
    localparam logic [5:0] K_IF       = 6'd3;
    localparam logic [5:0] K_ELSE     = 6'd4;
    localparam logic [5:0] K_WHILE    = 6'd5;
    localparam logic [5:0] K_BREAK    = 6'd6;
    localparam logic [5:0] K_CONTINUE = 6'd7;
    localparam logic [5:0] K_RETURN   = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd9;
    localparam logic [5:0] K_MINUS    = 6'd10;
    localparam logic [5:0] K_MUL      = 6'd11;
    localparam logic [5:0] K_DIV      = 6'd12;
    localparam logic [5:0] K_MOD      = 6'd13;
    localparam logic [5:0] K_LBRACE   = 6'd14;
    localparam logic [5:0] K_RBRACE   = 6'd15;
    localparam logic [5:0] K_LBRACKET = 6'd16;
    localparam logic [5:0] K_RBRACKET = 6'd17;
    localparam logic [5:0] K_LPAREN   = 6'd18;
    localparam logic [5:0] K_RPAREN   = 6'd19;
    localparam logic [5:0] K_COMMA    = 6'd20;
    localparam logic [5:0] K_SEMI     = 6'd21;
    localparam logic [5:0] K_ANDAND   = 6'd22;
    localparam logic [5:0] K_OROR     = 6'd23;
    localparam logic [5:0] K_NOT      = 6'd24;
    localparam logic [5:0] K_NE       = 6'd25;
    localparam logic [5:0] K_ASSIGN   = 6'd26;
    localparam logic [5:0] K_EQEQ     = 6'd27;
    localparam logic [5:0] K_LT       = 6'd28;
    localparam logic [5:0] K_LE       = 6'd29;
    localparam logic [5:0] K_GT       = 6'd30;
    localparam logic [5:0] K_GE       = 6'd31;
    localparam logic [5:0] K_NUMBER   = 6'd32;
    localparam logic [5:0] K_IDENT    = 6'd33;
    localparam logic [5:0] K_ERROR    = 6'd34;
    localparam logic [5:0] K_END      = 6'd35;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_BLOCK = 2'd1;
    localparam logic [1:0] E_HEX   = 2'd2;
    localparam logic [1:0] E_CHAR  = 2'd3;

    // One token as it leaves the scanner; the back end queues it for output.
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] value;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] line;
        logic [1:0]  cause;
        logic        eot;
    } t_tok;

    // Keyword kind for a packed prefix and length, identifier otherwise.
    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [31:0] n);
        logic [5:0] k;
        k = K_IDENT;
        if (n == 32'd5 && w == 64'h636F6E7374) k = K_CONST;
        if (n == 32'd3 && w == 64'h696E74) k = K_INT;
        if (n == 32'd4 && w == 64'h766F6964) k = K_VOID;
        if (n == 32'd2 && w == 64'h6966) k = K_IF;
        if (n == 32'd4 && w == 64'h656C7365) k = K_ELSE;
        if (n == 32'd5 && w == 64'h7768696C65) k = K_WHILE;
        if (n == 32'd5 && w == 64'h627265616B) k = K_BREAK;
        if (n == 32'd8 && w == 64'h636F6E74696E7565) k = K_CONTINUE;
        if (n == 32'd6 && w == 64'h72657475726E) k = K_RETURN;
        return k;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] h;
        h = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) h = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) h = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) h = 4'(c - 8'h37);
        return h;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

endpackage

@@ hdl/cst_front.sv @@
// Front end: scanner state machine that turns bytes into up to three tokens.
module cst_front
    import cst_pkg::*;
#(
    parameter int PositionWidth = PositionWidthDef,
    parameter int KeywordBytes  = KeywordBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic [1:0]  o_count,
    output t_tok        o_tok [3],
    input  logic        i_room
);

    localparam int PW = PositionWidth;

    t_mode            r_mode, n_mode;
    logic [31:0]      r_acc, n_acc;
    logic [63:0]      r_word, n_word;
    logic [31:0]      r_wlen, n_wlen;
    logic [PW-1:0]    r_orig, n_orig;
    logic [PW-1:0]    r_pos, n_pos;
    logic [31:0]      r_line, n_line;

    logic             go;
    logic             consumed;
    logic [PW-1:0]    here, nxt;
    logic [1:0]       cnt;
    t_tok             tk [3];
    t_tok             t_new;
    logic             have_new;
    logic [7:0]       c;

    assign o_ready = i_room;
    assign go      = i_valid & i_room;
    assign here    = r_pos;
    assign nxt     = r_pos + PW'(1);
    assign c       = i_byte;
    assign o_count = cnt;
    assign o_tok   = tk;

    function automatic t_tok mk(input logic [5:0] k, input logic [31:0] v,
                                input logic [PW-1:0] s, input logic [PW-1:0] l,
                                input logic [31:0] ln, input logic [1:0] e,
                                input logic eo);
        t_tok t;
        t.kind   = k;
        t.value  = v;
        t.start  = 32'(s);
        t.length = 32'(l);
        t.line   = ln;
        t.cause  = e;
        t.eot    = eo;
        return t;
    endfunction

    // Token held by a pending mode, flushed with end offset e.
    function automatic logic flush_tok(input t_mode m, input logic [31:0] acc,
                                       input logic [63:0] w, input logic [31:0] wl,
                                       input logic [PW-1:0] o, input logic [PW-1:0] e,
                                       input logic [31:0] ln, output t_tok t);
        logic [PW-1:0] l;
        logic          v;
        l = e - o;
        v = 1'b1;
        t = mk(K_ERROR, 32'd0, o, l, ln, E_NONE, 1'b0);
        case (m)
            M_IDENT: t.kind = word_kind(w, wl);
            M_DEC, M_HEX, M_OCT: begin
                t.kind = K_NUMBER;
                t.value = acc;
            end
            M_ZERO: t.kind = K_NUMBER;
            M_HEX0: t.cause = E_HEX;
            M_SLASH: t.kind = K_DIV;
            M_BLOCK, M_BSTAR: t.cause = E_BLOCK;
            M_BANG: t.kind = K_NOT;
            M_EQ: t.kind = K_ASSIGN;
            M_LT: t.kind = K_LT;
            M_GT: t.kind = K_GT;
            M_AMP, M_PIPE: t.cause = E_CHAR;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    always_comb begin
        t_tok   ft;
        logic   fv;
        t_tok   lst [3];
        logic [1:0] n;
        n_mode = r_mode; n_acc = r_acc; n_word = r_word; n_wlen = r_wlen;
        n_orig = r_orig; n_pos = r_pos; n_line = r_line;
        consumed = 1'b1;
        have_new = 1'b0;
        t_new = mk(K_END, 32'd0, here, '0, r_line, E_NONE, 1'b0);
        n = 2'd0;
        lst[0] = t_new; lst[1] = t_new; lst[2] = t_new;
        ft = t_new;
        fv = 1'b0;
        // Extend the pending token.
        case (r_mode)
            M_IDENT: begin
                consumed = is_alpha(c) | is_digit(c);
                if (consumed) begin
                    if (r_wlen < 32'(KeywordBytes)) n_word = {r_word[55:0], c};
                    if (r_wlen != 32'hFFFF_FFFF) n_wlen = r_wlen + 32'd1;
                end
            end
            M_DEC: begin
                consumed = is_digit(c);
                if (consumed) n_acc = (r_acc << 3) + (r_acc << 1) + 32'(c - 8'h30);
            end
            M_ZERO: begin
                if (c == 8'h78 || c == 8'h58) n_mode = M_HEX0;
                else if (c >= 8'h30 && c <= 8'h37) begin
                    n_mode = M_OCT;
                    n_acc = 32'(c - 8'h30);
                end else consumed = 1'b0;
            end
            M_HEX0, M_HEX: begin
                consumed = is_hex(c);
                if (consumed) begin
                    n_acc = (r_mode == M_HEX0 ? 32'd0 : r_acc << 4) + 32'(hex_val(c));
                    n_mode = M_HEX;
                end
            end
            M_OCT: begin
                consumed = c >= 8'h30 && c <= 8'h37;
                if (consumed) n_acc = (r_acc << 3) + 32'(c - 8'h30);
            end
            M_SLASH: begin
                if (c == 8'h2F) n_mode = M_LINE;
                else if (c == 8'h2A) n_mode = M_BLOCK;
                else consumed = 1'b0;
            end
            M_LINE: begin
                consumed = c != 8'h0A;
            end
            M_BLOCK, M_BSTAR: begin
                if (c == 8'h2F && r_mode == M_BSTAR) n_mode = M_IDLE;
                else if (c == 8'h2A) n_mode = M_BSTAR;
                else begin
                    if (c == 8'h0A) n_line = r_line + 32'd1;
                    n_mode = M_BLOCK;
                end
            end
            M_BANG, M_EQ, M_LT, M_GT: begin
                consumed = c == 8'h3D;
                if (consumed) begin
                    have_new = 1'b1;
                    t_new = mk(r_mode == M_BANG ? K_NE : r_mode == M_EQ ? K_EQEQ :
                               r_mode == M_LT ? K_LE : K_GE, 32'd0, r_orig,
                               nxt - r_orig, r_line, E_NONE, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_AMP, M_PIPE: begin
                consumed = c == (r_mode == M_AMP ? 8'h26 : 8'h7C);
                if (consumed) begin
                    have_new = 1'b1;
                    t_new = mk(r_mode == M_AMP ? K_ANDAND : K_OROR, 32'd0, r_orig,
                               nxt - r_orig, r_line, E_NONE, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            default: consumed = 1'b0;
        endcase
        if (!consumed) begin
            fv = flush_tok(r_mode, r_acc, r_word, r_wlen, r_orig, here, r_line, ft);
            if (fv) begin
                lst[n] = ft;
                n = n + 2'd1;
            end
            n_mode = M_IDLE;
            n_orig = here;
            t_new = mk(K_PLUS, 32'd0, here, PW'(1), r_line, E_NONE, 1'b0);
            case (c)
                8'h20, 8'h09, 8'h0D: ;
                8'h0A: n_line = r_line + 32'd1;
                8'h2F: n_mode = M_SLASH;
                8'h30: begin
                    n_mode = M_ZERO;
                    n_acc = 32'd0;
                end
                8'h2B: have_new = 1'b1;
                8'h2D: begin have_new = 1'b1; t_new.kind = K_MINUS; end
                8'h2A: begin have_new = 1'b1; t_new.kind = K_MUL; end
                8'h25: begin have_new = 1'b1; t_new.kind = K_MOD; end
                8'h7B: begin have_new = 1'b1; t_new.kind = K_LBRACE; end
                8'h7D: begin have_new = 1'b1; t_new.kind = K_RBRACE; end
                8'h5B: begin have_new = 1'b1; t_new.kind = K_LBRACKET; end
                8'h5D: begin have_new = 1'b1; t_new.kind = K_RBRACKET; end
                8'h28: begin have_new = 1'b1; t_new.kind = K_LPAREN; end
                8'h29: begin have_new = 1'b1; t_new.kind = K_RPAREN; end
                8'h2C: begin have_new = 1'b1; t_new.kind = K_COMMA; end
                8'h3B: begin have_new = 1'b1; t_new.kind = K_SEMI; end
                8'h21: n_mode = M_BANG;
                8'h3D: n_mode = M_EQ;
                8'h3C: n_mode = M_LT;
                8'h3E: n_mode = M_GT;
                8'h26: n_mode = M_AMP;
                8'h7C: n_mode = M_PIPE;
                default: begin
                    if (is_digit(c)) begin
                        n_mode = M_DEC;
                        n_acc = 32'(c - 8'h30);
                    end else if (is_alpha(c)) begin
                        n_mode = M_IDENT;
                        n_word = {56'd0, c};
                        n_wlen = 32'd1;
                    end else begin
                        have_new = 1'b1;
                        t_new.kind = K_ERROR;
                        t_new.cause = E_CHAR;
                    end
                end
            endcase
        end
        if (have_new) begin
            lst[n] = t_new;
            n = n + 2'd1;
        end
        n_pos = nxt;
        if (i_last) begin
            fv = flush_tok(n_mode, n_acc, n_word, n_wlen, n_orig, nxt, n_line, ft);
            if (fv) begin
                lst[n] = ft;
                n = n + 2'd1;
            end
            lst[n] = mk(K_END, 32'd0, nxt, '0, n_line, E_NONE, 1'b1);
            n = n + 2'd1;
            n_mode = M_IDLE; n_acc = '0; n_word = '0; n_wlen = '0;
            n_orig = '0; n_pos = '0; n_line = 32'd1;
        end
        tk = lst;
        cnt = go ? n : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_word <= '0;
            r_wlen <= '0;
            r_orig <= '0;
            r_pos  <= '0;
            r_line <= 32'd1;
        end else if (go) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_word <= n_word;
            r_wlen <= n_wlen;
            r_orig <= n_orig;
            r_pos  <= n_pos;
            r_line <= n_line;
        end
    end

endmodule

@@ hdl/cst_back.sv @@
// Back end: token queue that writes up to three tokens a cycle and drains one while ready.
module cst_back
    import cst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_count,
    input  t_tok        i_tok [3],
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_tok        o_tok
);

    localparam int Depth = 8;

    t_tok        r_q [Depth];
    logic [2:0]  r_wp, n_wp;
    logic [2:0]  r_rp, n_rp;
    logic [3:0]  r_cnt, n_cnt;
    logic        pop;

    assign o_valid = r_cnt != 4'd0;
    assign o_tok   = r_q[r_rp];
    assign pop     = o_valid & i_ready;
    // Room for a worst case of three tokens.
    assign o_room  = r_cnt <= 4'(Depth - 3);

    always_comb begin
        n_wp  = r_wp + 3'(i_count);
        n_rp  = r_rp + 3'(pop);
        n_cnt = r_cnt + 4'(i_count) - 4'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_count > 2'd0) r_q[r_wp] <= i_tok[0];
        if (i_count > 2'd1) r_q[r_wp + 3'd1] <= i_tok[1];
        if (i_count > 2'd2) r_q[r_wp + 3'd2] <= i_tok[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hdl/c_subset_tokenizer_core.sv @@
// Top level of the C subset tokenizer: scanner front end and token queue.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata = text_byte; tlast = is_last_byte
//  m_axis    | out       | tdata = value, start, length, line; tuser = kind, cause;
//            |           | tlast = end_of_text
//
// One byte is taken every cycle while the token queue has room for three
// more tokens; a byte yields at most three tokens, which the queue hands
// out one per cycle while the sink is ready. A token is queued with the
// byte that ends it. A stalled output only holds the input back once the
// queue has fewer than three free entries. Reset is synchronous and active
// low; it empties the queue and puts the scanner at offset 0, line 1.
module c_subset_tokenizer_core
    import cst_pkg::*;
#(
    parameter int POSITION_WIDTH = PositionWidthDef,
    parameter int KEYWORD_BYTES  = KeywordBytesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // text_byte [7:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // number_value [31:0], token_start [63:32], token_length [95:64],
    // line_number [127:96]
    output logic [127:0] m_axis_tdata,
    // token_kind [5:0], error_cause [7:6]
    output logic [7:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    logic [1:0] cnt;
    t_tok       toks [3];
    logic       room;
    t_tok       head;

    cst_front #(
        .PositionWidth(POSITION_WIDTH),
        .KeywordBytes (KEYWORD_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_count (cnt),
        .o_tok   (toks),
        .i_room  (room)
    );

    cst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (cnt),
        .i_tok   (toks),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (head)
    );

    assign m_axis_tdata = {head.line, head.length, head.start, head.value};
    assign m_axis_tuser = {head.cause, head.kind};
    assign m_axis_tlast = head.eot;

endmodule
